// ----- rtl/skt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the sorted key table: item structs, action and status codes.
package skt_pkg;

    localparam int ACTION_W = 2;
    localparam int IN_KEY_W = 30;
    localparam int IN_TAG_W = 16;
    localparam int RANK_W   = 6;
    localparam int STATUS_W = 2;
    localparam int OUT_KEY_W = 30;
    localparam int OUT_TAG_W = 16;
    localparam int OUT_CNT_W = 7;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_RANK  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [IN_KEY_W-1:0] key;
        logic [IN_TAG_W-1:0] tag;
        logic [RANK_W-1:0]   rank;
    } skt_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_KEY_W-1:0] out_key;
        logic [OUT_TAG_W-1:0] out_tag;
        logic [OUT_CNT_W-1:0] entry_count;
    } skt_result_t;

    // Per-cycle control broadcast to every cell of the row.
    typedef struct packed {
        logic capture;
        logic do_insert;
        logic do_delete;
    } skt_ctrl_t;

endpackage

// ----- rtl/skt_cell.sv -----
`timescale 1ns / 1ps
// One storage cell of the sorted row: a record, its valid bit and its compare flags.
module skt_cell #(
    parameter int KEY_BITS = 30,
    parameter int TAG_BITS = 16,
    parameter int INDEX    = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  skt_pkg::skt_ctrl_t        ctrl,
    input  logic [KEY_BITS-1:0]       op_key,
    input  logic [TAG_BITS-1:0]       op_tag,
    input  logic [skt_pkg::RANK_W-1:0] op_rank,
    input  logic                      left_valid,
    input  logic                      left_gt,
    input  logic [KEY_BITS-1:0]       left_key,
    input  logic [TAG_BITS-1:0]       left_tag,
    input  logic                      right_valid,
    input  logic [KEY_BITS-1:0]       right_key,
    input  logic [TAG_BITS-1:0]       right_tag,
    output logic                      valid,
    output logic                      gt,
    output logic                      eq,
    output logic                      hit,
    output logic [KEY_BITS-1:0]       key,
    output logic [TAG_BITS-1:0]       tag
);
    import skt_pkg::*;

    localparam bit REACHABLE = (INDEX < (1 << RANK_W));

    logic                valid_reg, valid_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;
    logic                gt_reg, ge_reg, eq_reg, hit_reg;

    // Insert: cells above the insertion point take their left neighbor, the
    // insertion point takes the new record. Delete: every cell at or above the
    // first match takes its right neighbor.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        tag_next   = tag_reg;
        if (ctrl.do_insert)
        begin
            valid_next = valid_reg | left_valid;
            if (left_gt)
            begin
                key_next = left_key;
                tag_next = left_tag;
            end
            else if (gt_reg || (!valid_reg && left_valid))
            begin
                key_next = op_key;
                tag_next = op_tag;
            end
        end
        else if (ctrl.do_delete && ge_reg)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        tag_reg <= tag_next;
        if (ctrl.capture)
        begin
            gt_reg  <= valid_reg && (key_reg > op_key);
            ge_reg  <= valid_reg && (key_reg >= op_key);
            eq_reg  <= valid_reg && (key_reg == op_key);
            hit_reg <= valid_reg && REACHABLE && (op_rank == RANK_W'(INDEX));
        end
    end

    assign valid = valid_reg;
    assign gt    = gt_reg;
    assign eq    = eq_reg;
    assign hit   = hit_reg;
    assign key   = key_reg;
    assign tag   = tag_reg;

endmodule

// ----- rtl/sorted_key_table.sv -----
`timescale 1ns / 1ps
// done strobes the result after the compare and update states; busy is high in between.
// One item at a time: accept, compare in every cell, then shift; start is ignored while busy.
// The receiver cannot stall; done strobes each result for one cycle only.
// Reset (rst_n, asynchronous, active low) empties the table: valid bits and count clear at once.
// Record contents are not reset; only valid cells are ever read.
module sorted_key_table #(
    parameter int TABLE_DEPTH = 64,
    parameter int KEY_BITS    = 30,
    parameter int TAG_BITS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  skt_pkg::skt_cmd_t    cmd,
    output logic                 done,
    output skt_pkg::skt_result_t result
);
    import skt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Sequencer: capture the item, let every cell compare, then shift and report.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                done_reg;
    skt_result_t         result_reg, result_next;

    logic [ACTION_W-1:0] op_action_reg;
    logic [KEY_BITS-1:0] op_key_reg;
    logic [TAG_BITS-1:0] op_tag_reg;
    logic [RANK_W-1:0]   op_rank_reg;

    skt_ctrl_t           ctrl;

    // Row of cells; index 0 holds the smallest key.
    logic [TABLE_DEPTH-1:0] valid_vec, gt_vec, eq_vec, hit_vec;
    logic [KEY_BITS-1:0]    key_vec [TABLE_DEPTH];
    logic [TAG_BITS-1:0]    tag_vec [TABLE_DEPTH];

    logic                   full, found, read_hit;
    logic [KEY_BITS-1:0]    bus_key;
    logic [TAG_BITS-1:0]    bus_tag;

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++)
        begin : g_cell
            logic                left_valid, left_gt, right_valid;
            logic [KEY_BITS-1:0] left_key, right_key;
            logic [TAG_BITS-1:0] left_tag, right_tag;

            if (gi == 0)
            begin : g_head
                // Cell 0 sees a full, smaller neighbor to its left.
                assign left_valid = 1'b1;
                assign left_gt    = 1'b0;
                assign left_key   = '0;
                assign left_tag   = '0;
            end
            else
            begin : g_mid_l
                assign left_valid = valid_vec[gi-1];
                assign left_gt    = gt_vec[gi-1];
                assign left_key   = key_vec[gi-1];
                assign left_tag   = tag_vec[gi-1];
            end

            if (gi == TABLE_DEPTH - 1)
            begin : g_tail
                // The last cell empties when the row shifts down.
                assign right_valid = 1'b0;
                assign right_key   = '0;
                assign right_tag   = '0;
            end
            else
            begin : g_mid_r
                assign right_valid = valid_vec[gi+1];
                assign right_key   = key_vec[gi+1];
                assign right_tag   = tag_vec[gi+1];
            end

            skt_cell #(
                .KEY_BITS (KEY_BITS),
                .TAG_BITS (TAG_BITS),
                .INDEX    (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .op_key      (op_key_reg),
                .op_tag      (op_tag_reg),
                .op_rank     (op_rank_reg),
                .left_valid  (left_valid),
                .left_gt     (left_gt),
                .left_key    (left_key),
                .left_tag    (left_tag),
                .right_valid (right_valid),
                .right_key   (right_key),
                .right_tag   (right_tag),
                .valid       (valid_vec[gi]),
                .gt          (gt_vec[gi]),
                .eq          (eq_vec[gi]),
                .hit         (hit_vec[gi]),
                .key         (key_vec[gi]),
                .tag         (tag_vec[gi])
            );
        end
    endgenerate

    // Table state as seen during the update cycle. Equal keys sit next to each
    // other, so the first match is the matching cell whose left neighbor does
    // not match.
    assign full     = (count_reg == CNT_W'(TABLE_DEPTH));
    assign found    = |eq_vec;
    assign read_hit = |hit_vec;

    // One-hot readout bus: the read cell or the first matching cell drives it.
    always_comb
    begin
        logic sel;
        bus_key = '0;
        bus_tag = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (op_action_reg == ACT_READ)
            begin
                sel = hit_vec[i];
            end
            else
            begin
                sel = eq_vec[i] && ((i == 0) ? 1'b1 : !eq_vec[(i == 0) ? 0 : i - 1]);
            end
            if (sel)
            begin
                bus_key = bus_key | key_vec[i];
                bus_tag = bus_tag | tag_vec[i];
            end
        end
    end

    always_comb
    begin
        ctrl.capture   = (state_reg == S_CMP);
        ctrl.do_insert = (state_reg == S_UPD) && (op_action_reg == ACT_INSERT) && !full;
        ctrl.do_delete = (state_reg == S_UPD) && (op_action_reg == ACT_DELETE) && found;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_CMP;
            S_CMP:   state_next = S_UPD;
            S_UPD:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Result and new count for the item in its update cycle.
    always_comb
    begin
        count_next          = count_reg;
        result_next.status  = ST_OK;
        result_next.out_key = '0;
        result_next.out_tag = '0;
        case (op_action_reg)
            ACT_INSERT:
            begin
                result_next.out_key = OUT_KEY_W'(op_key_reg);
                result_next.out_tag = OUT_TAG_W'(op_tag_reg);
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_DELETE:
            begin
                result_next.out_key = OUT_KEY_W'(op_key_reg);
                if (found)
                begin
                    result_next.out_tag = OUT_TAG_W'(bus_tag);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    result_next.status = ST_NOT_FOUND;
                end
            end
            ACT_READ:
            begin
                if (read_hit)
                begin
                    result_next.out_key = OUT_KEY_W'(bus_key);
                    result_next.out_tag = OUT_TAG_W'(bus_tag);
                end
                else
                begin
                    result_next.status = ST_BAD_RANK;
                end
            end
            default:
            begin
                result_next.status = ST_OK;
            end
        endcase
        result_next.entry_count = OUT_CNT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_UPD);
            if (state_reg == S_UPD)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            op_action_reg <= cmd.action;
            op_key_reg    <= KEY_BITS'(cmd.key);
            op_tag_reg    <= TAG_BITS'(cmd.tag);
            op_rank_reg   <= cmd.rank;
        end
        if (state_reg == S_UPD)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The number of occupied cells always equals the count.
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == 32'(count_reg))
        else $error("valid bits disagree with entry count");

    // Cell 0 is occupied exactly when the table is not empty.
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_vec[0] == (count_reg != '0))
        else $error("head cell occupancy disagrees with count");

    // A result strobes exactly once, right after the update cycle.
    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_UPD))
        else $error("result strobe without an update cycle");

    // An accepted item always keeps the block busy for the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && state_reg == S_CMP))
        else $error("accepted item did not enter the compare cycle");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the sorted key table: directed rows, then phased random traffic.
module tb;
    import skt_pkg::*;

    localparam int DEPTH      = 64;
    localparam int CMD_W      = $bits(skt_cmd_t);
    localparam int STALL_MAX  = 1000;
    localparam int PHASE_LEN  = 100;
    localparam logic [IN_KEY_W-1:0] KEY_TOP  = 30'h3FFF_FFFF;
    localparam logic [IN_KEY_W-1:0] KEY_HIGH = 30'd999999999;

    typedef enum int { PH_MIX, PH_FILL, PH_DRAIN } phase_t;

    typedef struct {
        skt_cmd_t    cmd;
        bit          typed;
        skt_result_t want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    skt_cmd_t    cmd;
    logic        done;
    skt_result_t result;

    // Shadow copy of the table, kept in ascending key order.
    logic [IN_KEY_W-1:0] shadow_key [DEPTH];
    logic [IN_TAG_W-1:0] shadow_tag [DEPTH];
    int                  shadow_count;

    skt_result_t pending_results [$];
    row_t        directed_rows [$];
    int          fail_count;
    int          stall_cycles;

    sorted_key_table u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Applies one item to the shadow table and returns the result it should produce.
    function automatic skt_result_t sorted_update(skt_cmd_t c);
        skt_result_t r;
        int          pos;
        r = '0;
        pos = 0;
        case (c.action)
            ACT_INSERT:
            begin
                if (shadow_count >= DEPTH) begin
                    r.status  = ST_FULL;
                    r.out_key = c.key;
                    r.out_tag = c.tag;
                end
                else begin
                    // Equal keys stay ahead of the new record.
                    while (pos < shadow_count && shadow_key[pos] <= c.key)
                        pos++;
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_key[i] = shadow_key[i-1];
                        shadow_tag[i] = shadow_tag[i-1];
                    end
                    shadow_key[pos] = c.key;
                    shadow_tag[pos] = c.tag;
                    shadow_count++;
                    r.status  = ST_OK;
                    r.out_key = c.key;
                    r.out_tag = c.tag;
                end
            end
            ACT_DELETE:
            begin
                while (pos < shadow_count && shadow_key[pos] != c.key)
                    pos++;
                r.out_key = c.key;
                if (pos >= shadow_count) begin
                    r.status = ST_NOT_FOUND;
                end
                else begin
                    r.status  = ST_OK;
                    r.out_tag = shadow_tag[pos];
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_key[i] = shadow_key[i+1];
                        shadow_tag[i] = shadow_tag[i+1];
                    end
                    shadow_count--;
                end
            end
            ACT_READ:
            begin
                if (int'(c.rank) >= shadow_count) begin
                    r.status = ST_BAD_RANK;
                end
                else begin
                    r.status  = ST_OK;
                    r.out_key = shadow_key[c.rank];
                    r.out_tag = shadow_tag[c.rank];
                end
            end
            default:
            begin
                r.status = ST_OK;
            end
        endcase
        r.entry_count = OUT_CNT_W'(shadow_count);
        return r;
    endfunction

    // Keys cluster on small values (0 to 15) and on zero, KEY_TOP and KEY_HIGH so that duplicates are common.
    function automatic logic [IN_KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return IN_KEY_W'($urandom_range(0, 15));
        else if (roll < 34)
            return '0;
        else if (roll < 38)
            return KEY_TOP;
        else if (roll < 42)
            return KEY_HIGH;
        else
            return IN_KEY_W'($urandom);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Holds one item on the bus until the block takes it, then records its expected result.
    task automatic send_item(input skt_cmd_t c, input bit typed, input skt_result_t want);
        skt_result_t model_res;
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        model_res = sorted_update(c);
        pending_results.push_back(typed ? want : model_res);
    endtask

    // Lowers start for an idle gap of length n; the command bus carries noise meanwhile.
    task automatic idle_for(input int n);
        repeat (n) begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= CMD_W'({$urandom, $urandom});
        end
    endtask

    task automatic add_row(input logic [ACTION_W-1:0] act, input logic [IN_KEY_W-1:0] k,
                           input logic [IN_TAG_W-1:0] t, input logic [RANK_W-1:0] rk,
                           input bit typed, input logic [STATUS_W-1:0] st,
                           input logic [OUT_KEY_W-1:0] ok, input logic [OUT_TAG_W-1:0] ot,
                           input logic [OUT_CNT_W-1:0] cnt);
        row_t row;
        row.cmd   = '{action: act, key: k, tag: t, rank: rk};
        row.typed = typed;
        row.want  = '{status: st, out_key: ok, out_tag: ot, entry_count: cnt};
        directed_rows.push_back(row);
    endtask

    // Every strobed result is matched against the oldest outstanding expectation.
    always @(posedge clk) begin
        skt_result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual st=%0d key=%h tag=%h cnt=%0d",
                         $time, result.status, result.out_key, result.out_tag,
                         result.entry_count);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (result !== want) begin
                    $display("%0t: mismatch, expected st=%0d key=%h tag=%h cnt=%0d",
                             $time, want.status, want.out_key, want.out_tag,
                             want.entry_count);
                    $display("%0t:           actual   st=%0d key=%h tag=%h cnt=%0d",
                             $time, result.status, result.out_key, result.out_tag,
                             result.entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Ends the run if neither an item nor a result moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((start && !busy) || done)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_MAX) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        phase_t      schedule [7];
        skt_cmd_t    c;
        skt_result_t none;
        int          roll;
        bit          no_idle;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        shadow_count = 0;
        fail_count   = 0;
        stall_cycles = 0;
        none         = '0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_key[i] = '0;
            shadow_tag[i] = '0;
        end

        // Directed rows: empty table, extremes, equal keys, head and tail deletes, misses.
        add_row(ACT_READ,   0,        0,       0,  1, ST_BAD_RANK,  0,        0,       0);
        add_row(ACT_DELETE, 5,        0,       0,  1, ST_NOT_FOUND, 5,        0,       0);
        add_row(ACT_NOP,    KEY_TOP,  16'hFFFF, 63, 1, ST_OK,       0,        0,       0);
        add_row(ACT_INSERT, 0,        0,       0,  1, ST_OK,        0,        0,       1);
        add_row(ACT_INSERT, KEY_TOP,  16'hFFFF, 63, 1, ST_OK,       KEY_TOP,  16'hFFFF, 2);
        add_row(ACT_INSERT, KEY_HIGH, 16'h1234, 0, 1, ST_OK,        KEY_HIGH, 16'h1234, 3);
        add_row(ACT_INSERT, 500,      1,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_INSERT, 500,      2,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       1,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       2,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       63, 1, ST_BAD_RANK,  0,        0,       5);
        add_row(ACT_READ,   0,        0,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_DELETE, 0,        0,       0,  1, ST_OK,        0,        0,       4);
        add_row(ACT_DELETE, 500,      0,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_DELETE, 12345,    0,       0,  1, ST_NOT_FOUND, 12345,    0,       3);
        add_row(ACT_DELETE, KEY_TOP,  0,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       2,  1, ST_BAD_RANK,  0,        0,       2);
        add_row(ACT_NOP,    KEY_TOP,  16'hFFFF, 63, 1, ST_OK,       0,        0,       2);
        add_row(ACT_INSERT, KEY_HIGH, 7,       0,  0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       2,  0, ST_OK,        0,        0,       0);
        add_row(ACT_INSERT, 1,        16'hAAAA, 0, 0, ST_OK,        0,        0,       0);
        add_row(ACT_READ,   0,        0,       0,  0, ST_OK,        0,        0,       0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            idle_for(pick_gap());
        end

        // Random phases: filling favours inserts to run the table toward full, draining favours deletes to empty it.
        schedule = '{PH_MIX, PH_FILL, PH_DRAIN, PH_MIX, PH_FILL, PH_MIX, PH_DRAIN};
        foreach (schedule[p]) begin
            no_idle = ($urandom_range(0, 2) == 0);
            repeat (PHASE_LEN) begin
                c      = CMD_W'({$urandom, $urandom});
                c.key  = pick_key();
                roll   = $urandom_range(0, 99);
                case (schedule[p])
                    PH_FILL:  c.action = roll < 80 ? ACT_INSERT : roll < 88 ? ACT_DELETE :
                                         roll < 97 ? ACT_READ : ACT_NOP;
                    PH_DRAIN: c.action = roll < 10 ? ACT_INSERT : roll < 80 ? ACT_DELETE :
                                         roll < 97 ? ACT_READ : ACT_NOP;
                    default:  c.action = roll < 40 ? ACT_INSERT : roll < 70 ? ACT_DELETE :
                                         roll < 95 ? ACT_READ : ACT_NOP;
                endcase
                // Most deletes and reads aim at stored records so that they hit.
                if (shadow_count > 0 && $urandom_range(0, 99) < 75) begin
                    if (c.action == ACT_DELETE)
                        c.key = shadow_key[$urandom_range(0, shadow_count - 1)];
                    else if (c.action == ACT_READ)
                        c.rank = RANK_W'($urandom_range(0, shadow_count - 1));
                end
                send_item(c, 1'b0, none);
                if (!no_idle)
                    idle_for(pick_gap());
            end
        end

        idle_for(1);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sorted_key_table.f -----
rtl/skt_pkg.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
test/tb.sv
